>>> hdl/mwf_pkg.sv
// ----------------------------------------------------------------------------
// mwf_pkg
// Shared types, constants and helpers for the median window filter.
// ----------------------------------------------------------------------------
package mwf_pkg;

  localparam int PIX_W         = 8;
  localparam int DEF_RADIUS    = 1;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_KAREA     = (2 * DEF_RADIUS + 1) * (2 * DEF_RADIUS + 1);
  localparam int HEIGHT_CAP    = 4096;
  localparam int SIZE_W        = 13;
  localparam int ROW_W         = $clog2(HEIGHT_CAP + 1);
  localparam int CFG_IDX_W     = 2;

  localparam int DEF_IMAGE_WIDTH  = 640;
  localparam int DEF_IMAGE_HEIGHT = 480;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             start_of_frame;
    logic             flush;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_frame;
  } out_word_t;

  // travels alongside the window through the sort chain
  typedef struct packed {
    logic [PIX_W-1:0] center;
    logic             interior;
    logic             end_of_frame;
  } side_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lo,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    r = v;
    if (r < lo) begin
      r = lo;
    end
    if (r > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

>>> hdl/mwf_line_buffer.sv
// ----------------------------------------------------------------------------
// mwf_line_buffer
// Line memory, one word per column holding the pixels of the rows above.
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mwf_line_buffer #(
  parameter int DEPTH  = mwf_pkg::DEF_MAX_WIDTH,
  parameter int WORD_W = 2 * mwf_pkg::DEF_RADIUS * mwf_pkg::PIX_W
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WORD_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WORD_W-1:0]        wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/mwf_sort_cell.sv
// ----------------------------------------------------------------------------
// mwf_sort_cell
// One stage of an odd-even transposition sorter: compare-exchange on
// alternate pairs, registered, with its own valid and hand-on control.
// ----------------------------------------------------------------------------
module mwf_sort_cell #(
  parameter int N      = mwf_pkg::DEF_KAREA,
  parameter int PARITY = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  input  logic [N-1:0][mwf_pkg::PIX_W-1:0] up_data,
  input  mwf_pkg::side_t                   up_side,
  output logic                             up_take,
  input  logic                             down_take,
  output logic                             valid_o,
  output logic [N-1:0][mwf_pkg::PIX_W-1:0] data_o,
  output mwf_pkg::side_t                   side_o
);

  logic                             valid_r;
  logic [N-1:0][mwf_pkg::PIX_W-1:0] data_r;
  logic [N-1:0][mwf_pkg::PIX_W-1:0] data_nxt;
  mwf_pkg::side_t                   side_r;

  always_comb begin
    data_nxt = up_data;
    for (int m = 0; m < N / 2; m++) begin
      if (2 * m + PARITY + 1 < N) begin
        if (up_data[2 * m + PARITY] > up_data[2 * m + PARITY + 1]) begin
          data_nxt[2 * m + PARITY]     = up_data[2 * m + PARITY + 1];
          data_nxt[2 * m + PARITY + 1] = up_data[2 * m + PARITY];
        end
      end
    end
  end

  assign up_take = !valid_r || down_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_take) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_take) begin
      data_r <= data_nxt;
      side_r <= up_side;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;
  assign side_o  = side_r;

endmodule

>>> hdl/median_window_filter_unit.sv
// ----------------------------------------------------------------------------
// median_window_filter_unit
// Streaming square-window median filter for 8-bit grey raster images.
// ----------------------------------------------------------------------------
// Takes one word per clock while in_stall is low; an accepted word passes
// through the line memory read and the window register, then the odd-even
// transposition sorter of KAREA cells, KAREA = (2*RADIUS+1)^2 (one cell per
// sort step), and the output register. Results lag the input stream by
// RADIUS rows plus RADIUS pixels; after the last pixel of a frame, flush
// words drain the remaining results, one each. The line memory holds
// MAX_WIDTH words of 2*RADIUS pixels and needs no clearing after reset.
// Writing a size register restarts the frame; sizes are clamped to
// [2*RADIUS+1, MAX_WIDTH] and [2*RADIUS+1, 4096].
// ----------------------------------------------------------------------------
module median_window_filter_unit #(
  parameter int RADIUS    = mwf_pkg::DEF_RADIUS,
  parameter int MAX_WIDTH = mwf_pkg::DEF_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mwf_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mwf_pkg::out_word_t              out_data,
  input  logic                            cfg_we,
  input  logic [mwf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mwf_pkg::SIZE_W-1:0]      cfg_wdata
);

  localparam int PIX_W  = mwf_pkg::PIX_W;
  localparam int KSIDE  = 2 * RADIUS + 1;
  localparam int KAREA  = KSIDE * KSIDE;
  localparam int MID    = KAREA / 2;
  localparam int LINES  = 2 * RADIUS;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = mwf_pkg::ROW_W;
  localparam int SIZE_W = mwf_pkg::SIZE_W;

  // sizes
  logic [WID_W-1:0]  w_eff_r, w_eff_nxt;
  logic [ROW_W-1:0]  h_eff_r, h_eff_nxt;
  logic [SIZE_W-1:0] w_clamped, h_clamped, w_reset, h_reset;
  logic              cfg_hit;

  // positions
  logic [COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic             full_r, full_nxt;
  logic [COL_W-1:0] cur_in_col, cur_out_col;
  logic [ROW_W-1:0] cur_in_row, cur_out_row;
  logic             cur_full;

  logic in_fire, sof, pix_wr, primed, emit_fl, emit, shift;
  logic in_col_last, out_col_last, interior, eof;

  // line memory stage
  logic                         s1_valid_r, s1_emit_r, s1_int_r, s1_eof_r, s1_adv;
  logic [PIX_W-1:0]             s1_pix_r;
  logic [COL_W-1:0]             s1_col_r;
  logic [LINES-1:0][PIX_W-1:0]  rd_word, wr_word;
  logic [KSIDE-1:0][PIX_W-1:0]  col_vec;

  // window stage
  logic [KSIDE-1:0][KSIDE-1:0][PIX_W-1:0] win_r;
  logic                                   s2_valid_r, s2_int_r, s2_eof_r;

  // sort chain
  logic [KAREA:0]                st_valid, st_take;
  logic [KAREA-1:0][PIX_W-1:0]   st_data [KAREA+1];
  mwf_pkg::side_t                st_side [KAREA+1];

  // output register
  logic               out_valid_r, out_take;
  mwf_pkg::out_word_t out_data_r, out_word_nxt;

  // configuration
  always_comb begin
    w_clamped = mwf_pkg::clamp_size({1'b0, cfg_wdata[SIZE_W-2:0]}, SIZE_W'(KSIDE),
                                    SIZE_W'(MAX_WIDTH));
    h_clamped = mwf_pkg::clamp_size(cfg_wdata, SIZE_W'(KSIDE),
                                    SIZE_W'(mwf_pkg::HEIGHT_CAP));
    w_reset   = mwf_pkg::clamp_size(SIZE_W'(mwf_pkg::DEF_IMAGE_WIDTH), SIZE_W'(KSIDE),
                                    SIZE_W'(MAX_WIDTH));
    h_reset   = mwf_pkg::clamp_size(SIZE_W'(mwf_pkg::DEF_IMAGE_HEIGHT), SIZE_W'(KSIDE),
                                    SIZE_W'(mwf_pkg::HEIGHT_CAP));
    w_eff_nxt = w_eff_r;
    h_eff_nxt = h_eff_r;
    cfg_hit   = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        mwf_pkg::REG_IMAGE_WIDTH: begin
          w_eff_nxt = w_clamped[WID_W-1:0];
          cfg_hit   = 1'b1;
        end
        mwf_pkg::REG_IMAGE_HEIGHT: begin
          h_eff_nxt = h_clamped[ROW_W-1:0];
          cfg_hit   = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= w_reset[WID_W-1:0];
      h_eff_r <= h_reset[ROW_W-1:0];
    end else begin
      w_eff_r <= w_eff_nxt;
      h_eff_r <= h_eff_nxt;
    end
  end

  // input decode and position tracking
  assign in_fire = in_valid && !in_stall;

  always_comb begin
    sof         = in_data.start_of_frame && !in_data.flush;
    cur_in_col  = in_col_r;
    cur_in_row  = in_row_r;
    cur_out_col = out_col_r;
    cur_out_row = out_row_r;
    cur_full    = full_r;
    if (sof) begin
      cur_in_col  = '0;
      cur_in_row  = '0;
      cur_out_col = '0;
      cur_out_row = '0;
      cur_full    = 1'b0;
    end
    pix_wr  = !in_data.flush && !cur_full;
    primed  = (cur_in_row > ROW_W'(RADIUS)) ||
              ((cur_in_row == ROW_W'(RADIUS)) && (cur_in_col >= COL_W'(RADIUS)));
    emit_fl = in_data.flush && full_r && (out_row_r < h_eff_r);
    emit    = (pix_wr && primed) || emit_fl;
    shift   = pix_wr || emit_fl;

    in_col_last  = WID_W'(cur_in_col) == w_eff_r - WID_W'(1);
    out_col_last = WID_W'(cur_out_col) == w_eff_r - WID_W'(1);
    interior     = (cur_out_row >= ROW_W'(RADIUS)) &&
                   (cur_out_row < h_eff_r - ROW_W'(RADIUS)) &&
                   (cur_out_col >= COL_W'(RADIUS)) &&
                   (WID_W'(cur_out_col) < w_eff_r - WID_W'(RADIUS));
    eof          = (cur_out_row == h_eff_r - ROW_W'(1)) && out_col_last;

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    full_nxt    = full_r;
    if (in_fire) begin
      in_col_nxt  = cur_in_col;
      in_row_nxt  = cur_in_row;
      out_col_nxt = cur_out_col;
      out_row_nxt = cur_out_row;
      full_nxt    = cur_full;
      if (shift) begin
        in_col_nxt = in_col_last ? '0 : cur_in_col + COL_W'(1);
      end
      if (pix_wr && in_col_last) begin
        in_row_nxt = cur_in_row + ROW_W'(1);
        if (cur_in_row == h_eff_r - ROW_W'(1)) begin
          full_nxt = 1'b1;
        end
      end
      if (emit) begin
        out_col_nxt = out_col_last ? '0 : cur_out_col + COL_W'(1);
        if (out_col_last) begin
          out_row_nxt = cur_out_row + ROW_W'(1);
        end
      end
    end
    if (cfg_hit) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      full_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      full_r    <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      full_r    <= full_nxt;
    end
  end

  // line memory: read when an accepted word shifts the window, write back when the word moves on
  mwf_line_buffer #(
    .DEPTH  (MAX_WIDTH),
    .WORD_W (LINES * PIX_W)
  ) u_line_buffer (
    .clk     (clk),
    .rd_en   (in_fire && shift),
    .rd_addr (cur_in_col),
    .rd_data (rd_word),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (wr_word)
  );

  always_comb begin
    col_vec[0] = s1_pix_r;
    wr_word[0] = s1_pix_r;
    for (int k = 1; k < KSIDE; k++) begin
      col_vec[k] = rd_word[k-1];
    end
    for (int e = 1; e < LINES; e++) begin
      wr_word[e] = rd_word[e-1];
    end
  end

  assign s1_adv   = s1_valid_r && (!s2_valid_r || st_take[0]);
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire && shift) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && shift) begin
      s1_pix_r  <= in_data.flush ? '0 : in_data.pixel_in;
      s1_col_r  <= cur_in_col;
      s1_emit_r <= emit;
      s1_int_r  <= interior;
      s1_eof_r  <= eof;
    end
  end

  // window: a row of column cells, newest column at index 0
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_r[0] <= col_vec;
      for (int j = 1; j < KSIDE; j++) begin
        win_r[j] <= win_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_r <= s1_emit_r;
    end else if (st_take[0]) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_int_r <= s1_int_r;
      s2_eof_r <= s1_eof_r;
    end
  end

  always_comb begin
    for (int j = 0; j < KSIDE; j++) begin
      for (int k = 0; k < KSIDE; k++) begin
        st_data[0][j * KSIDE + k] = win_r[j][k];
      end
    end
    st_side[0].center       = win_r[RADIUS][RADIUS];
    st_side[0].interior     = s2_int_r;
    st_side[0].end_of_frame = s2_eof_r;
  end

  assign st_valid[0] = s2_valid_r;

  // sorter
  for (genvar i = 0; i < KAREA; i++) begin : g_sort
    mwf_sort_cell #(
      .N      (KAREA),
      .PARITY (i % 2)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (st_valid[i]),
      .up_data   (st_data[i]),
      .up_side   (st_side[i]),
      .up_take   (st_take[i]),
      .down_take (st_take[i+1]),
      .valid_o   (st_valid[i+1]),
      .data_o    (st_data[i+1]),
      .side_o    (st_side[i+1])
    );
  end

  // output register
  assign out_take        = !out_valid_r || !out_stall;
  assign st_take[KAREA]  = out_take;

  always_comb begin
    out_word_nxt.pixel_out    = st_side[KAREA].interior ? st_data[KAREA][MID]
                                                        : st_side[KAREA].center;
    out_word_nxt.end_of_frame = st_side[KAREA].end_of_frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= st_valid[KAREA];
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_data_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
